// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // default fraction bits of the fixed-point results
  localparam int FRAC_BITS   = 16;
  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  // coefficient width
  localparam int COEF_W      = 16;
  // magnitude of the discriminant, in bits and in bit pairs
  localparam int MAG_PAIRS   = 17;
  localparam int MAG_W       = 2 * MAG_PAIRS;
  // magnitude of 2a
  localparam int DEN_W       = 17;
  // result width
  localparam int OUT_W       = 40;

  // kind of root pair
  typedef enum logic [1:0] {
    KIND_DISTINCT = 2'd0,
    KIND_REPEATED = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_e;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/qrs_queue.sv =====
// ----------------------------------------------------------------------------
// qrs_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module qrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     data_o,
  output qrs_pkg::q_stat_t     stat_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;

  // status from pointer compare
  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.full  = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) &&
                        (wr_ptr_q[PW-1] != rd_ptr_q[PW-1]);

  assign wr_ptr_d = push_i ? wr_ptr_q + PW'(1) : wr_ptr_q;
  assign rd_ptr_d = pop_i  ? rd_ptr_q + PW'(1) : rd_ptr_q;
  assign data_o   = mem[rd_ptr_q[AW-1:0]];

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q[AW-1:0]] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficients, forms the discriminant and classifies the equation.
// ----------------------------------------------------------------------------
module qrs_front #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS,
  parameter int ENTRY_W   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c_i,
  input  qrs_pkg::q_stat_t                  q_stat_i,
  output logic                              push_o,
  output logic [ENTRY_W-1:0]                entry_o
);

  localparam int CW = qrs_pkg::COEF_W;
  localparam int BW = CW + 1 + FRAC_BITS;
  localparam int DW = 35;

  // stage one: products
  logic                 s1_valid_q;
  logic signed [31:0]   bb_q, ac_q;
  logic signed [CW-1:0] a1_q, b1_q;
  // stage two: classified entry
  logic                 s2_valid_q;
  logic [ENTRY_W-1:0]   entry_q, entry_d;
  logic                 s1_ready, s2_ready;

  logic signed [DW-1:0] disc;
  logic [qrs_pkg::MAG_W-1:0] mag;
  logic [CW-1:0]        a_mag;
  logic signed [BW-1:0] base;
  qrs_pkg::kind_e       kind;

  assign s2_ready = !s2_valid_q || !q_stat_i.full;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign push_o   = s2_valid_q && !q_stat_i.full;
  assign entry_o  = entry_q;

  // discriminant, magnitudes and kind
  always_comb begin
    disc  = $signed({{(DW-32){bb_q[31]}}, bb_q}) -
            $signed({{(DW-34){ac_q[31]}}, ac_q, 2'b00});
    mag   = disc[DW-1] ? qrs_pkg::MAG_W'(-disc) : qrs_pkg::MAG_W'(disc);
    a_mag = a1_q[CW-1] ? CW'(-a1_q) : CW'(a1_q);
    base  = -($signed({{(BW-CW){b1_q[CW-1]}}, b1_q}) <<< FRAC_BITS);
    if (a1_q == '0) begin
      kind = qrs_pkg::KIND_INVALID;
    end else if (disc == '0) begin
      kind = qrs_pkg::KIND_REPEATED;
    end else if (disc[DW-1]) begin
      kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      kind = qrs_pkg::KIND_DISTINCT;
    end
    entry_d = {kind, a1_q[CW-1], a_mag, 1'b0, mag, base};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      bb_q <= 32'(coef_b_i) * 32'(coef_b_i);
      ac_q <= 32'(coef_a_i) * 32'(coef_c_i);
      a1_q <= coef_a_i;
      b1_q <= coef_b_i;
    end
    if (s2_ready) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== hw/rtl/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [qrs_pkg::MAG_W-1:0]     mag_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [qrs_pkg::MAG_PAIRS+FRAC_BITS-1:0] root_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int N  = qrs_pkg::MAG_PAIRS + FRAC_BITS;
  localparam int RW = N + 3;
  localparam int MW = qrs_pkg::MAG_W;

  logic              valid_q [N];
  logic [RW-1:0]     rem_q   [N];
  logic [N-1:0]      root_q  [N];
  logic [MW-1:0]     mag_q   [N];
  logic [SIDE_W-1:0] side_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              v_in;
    logic [RW-1:0]     rem_in, rem_sh, trial, rem_nx;
    logic [N-1:0]      root_in;
    logic [MW-1:0]     mag_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign mag_in  = mag_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign mag_in  = mag_q[i-1];
      assign side_in = side_q[i-1];
    end

    // one trial subtraction per stage
    assign rem_sh = {rem_in[RW-3:0], mag_in[MW-1:MW-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_nx = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_nx;
        root_q[i] <= {root_in[N-2:0], ge};
        mag_q[i]  <= mag_in << 2;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ===== hw/rtl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [FRAC_BITS+17:0]      num_i,
  input  logic [qrs_pkg::DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [FRAC_BITS+17:0]      quo_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int NM = FRAC_BITS + 18;
  localparam int DW = qrs_pkg::DEN_W;

  logic              valid_q [NM];
  logic [DW-1:0]     rem_q   [NM];
  logic [NM-1:0]     quo_q   [NM];
  logic [NM-1:0]     num_q   [NM];
  logic [DW-1:0]     den_q   [NM];
  logic [SIDE_W-1:0] side_q  [NM];

  for (genvar i = 0; i < NM; i++) begin : g_stage
    logic              v_in;
    logic [DW-1:0]     rem_in, den_in;
    logic [NM-1:0]     quo_in, num_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW:0]       rem_sh, diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign num_in  = num_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // shift in next numerator bit and try the subtraction
    assign rem_sh = {rem_in, num_in[NM-1]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        quo_q[i]  <= {quo_in[NM-2:0], ge};
        num_q[i]  <= num_in << 1;
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NM-1];
  assign quo_o   = quo_q[NM-1];
  assign side_o  = side_q[NM-1];

endmodule

// ===== hw/rtl/qrs_back.sv =====
// ----------------------------------------------------------------------------
// qrs_back
// Takes classified entries, runs square root and divisions, holds result.
// ----------------------------------------------------------------------------
module qrs_back #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS,
  parameter int ENTRY_W   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ENTRY_W-1:0]                entry_i,
  input  qrs_pkg::q_stat_t                  q_stat_i,
  output logic                              pop_o,
  output logic                              valid_o,
  input  logic                              ready_i,
  output qrs_pkg::kind_e                    root_kind_o,
  output logic signed [qrs_pkg::OUT_W-1:0]  first_value_o,
  output logic signed [qrs_pkg::OUT_W-1:0]  second_value_o
);

  localparam int BW  = qrs_pkg::COEF_W + 1 + FRAC_BITS;
  localparam int MW  = qrs_pkg::MAG_W;
  localparam int DNW = qrs_pkg::DEN_W;
  localparam int N   = qrs_pkg::MAG_PAIRS + FRAC_BITS;
  localparam int NM  = FRAC_BITS + 18;
  localparam int NW  = NM + 1;
  localparam int OW  = qrs_pkg::OUT_W;
  localparam int XW  = (NM > OW ? NM : OW) + 1;
  localparam int SW  = 3 + DNW + BW;

  logic en;

  // entry fields
  logic [BW-1:0]  e_base;
  logic [MW-1:0]  e_mag;
  logic [SW-1:0]  e_side;
  assign e_base = entry_i[BW-1:0];
  assign e_mag  = entry_i[BW+MW-1:BW];
  assign e_side = {entry_i[BW+MW+DNW+2:BW+MW], e_base};

  // whole back pipeline advances unless a result waits
  assign en    = !valid_o || ready_i;
  assign pop_o = en && !q_stat_i.empty;

  logic          sq_valid;
  logic [N-1:0]  sq_root;
  logic [SW-1:0] sq_side;

  qrs_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (!q_stat_i.empty),
    .mag_i   (e_mag),
    .side_i  (e_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // numerators by case
  qrs_pkg::kind_e       sq_kind;
  logic                 sq_a_neg;
  logic signed [NW-1:0] base_x, root_x, n1, n2;
  logic [NM-1:0]        m1_d, m2_d;
  assign sq_kind  = qrs_pkg::kind_e'(sq_side[SW-1:SW-2]);
  assign sq_a_neg = sq_side[SW-3];
  assign base_x   = $signed({{(NW-BW){sq_side[BW-1]}}, sq_side[BW-1:0]});
  assign root_x   = $signed({{(NW-N){1'b0}}, sq_root});

  always_comb begin
    if (sq_kind == qrs_pkg::KIND_COMPLEX) begin
      n1 = base_x;
      n2 = root_x;
    end else begin
      n1 = base_x + root_x;
      n2 = base_x - root_x;
    end
    m1_d = n1[NW-1] ? NM'(-n1) : NM'(n1);
    m2_d = n2[NW-1] ? NM'(-n2) : NM'(n2);
  end

  logic           nm_valid_q;
  logic [NM-1:0]  m1_q, m2_q;
  logic           sg1_q, sg2_q;
  logic [1:0]     nk_q;
  logic [DNW-1:0] den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_valid_q <= 1'b0;
    end else if (en) begin
      nm_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      sg1_q <= n1[NW-1] ^ sq_a_neg;
      sg2_q <= n2[NW-1] ^ sq_a_neg;
      nk_q  <= sq_kind;
      den_q <= sq_side[BW+DNW-1:BW];
    end
  end

  logic          d1_valid, d2_valid;
  logic [NM-1:0] q1, q2;
  logic [2:0]    d1_side;
  logic          d2_side;

  qrs_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(3)) u_div_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid_q),
    .num_i   (m1_q),
    .den_i   (den_q),
    .side_i  ({nk_q, sg1_q}),
    .valid_o (d1_valid),
    .quo_o   (q1),
    .side_o  (d1_side)
  );

  qrs_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid_q),
    .num_i   (m2_q),
    .den_i   (den_q),
    .side_i  (sg2_q),
    .valid_o (d2_valid),
    .quo_o   (q2),
    .side_o  (d2_side)
  );

  // apply sign and saturate to the result range
  function automatic logic [OW-1:0] fix_out(input logic [NM-1:0] mag, input logic neg);
    logic [XW-1:0] mx, lim;
    mx  = XW'(mag);
    lim = XW'(1) << (OW - 1);
    if (!neg) begin
      fix_out = (mx >= lim) ? {1'b0, {(OW-1){1'b1}}} : mx[OW-1:0];
    end else begin
      fix_out = (mx > lim) ? {1'b1, {(OW-1){1'b0}}} : OW'(-mx);
    end
  endfunction

  qrs_pkg::kind_e d_kind;
  logic           out_valid_q;
  qrs_pkg::kind_e kind_q;
  logic [OW-1:0]  first_q, second_q, first_d, second_d;

  assign d_kind = qrs_pkg::kind_e'(d1_side[2:1]);

  always_comb begin
    if (d_kind == qrs_pkg::KIND_INVALID) begin
      first_d  = '0;
      second_d = '0;
    end else begin
      first_d  = fix_out(q1, d1_side[0]);
      second_d = fix_out(q2, d2_side);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d1_valid && d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q   <= d_kind;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign valid_o        = out_valid_q;
  assign root_kind_o    = kind_q;
  assign first_value_o  = first_q;
  assign second_value_o = second_q;

endmodule

// ===== hw/rtl/quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Roots of a*x^2 + b*x + c in signed fixed point, one equation per transfer.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                   | tuser
//  s_axis   | in  | coef_a, coef_b, coef_c (48 bits)     | -
//  m_axis   | out | first_value, second_value (80 bits)  | root_kind
//
//  one equation per cycle sustained unless the output stalls; equations
//  pass front product and entry registers, the queue, 17+FRAC_BITS square
//  root, one numerator, 18+FRAC_BITS divider stages and the output register.
//  reset clears all valid flags and queue pointers; no clearing pass.
//  a stalled output freezes the back pipeline; the queue lets the front
//  keep taking transfers until it fills.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
  parameter int FRAC_BITS   = qrs_pkg::FRAC_BITS,
  parameter int QUEUE_DEPTH = qrs_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // coef_a, coef_b, coef_c
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // first_value, second_value
  output logic [1:0]  m_axis_tuser_o    // root_kind
);

  localparam int BW      = qrs_pkg::COEF_W + 1 + FRAC_BITS;
  localparam int ENTRY_W = BW + qrs_pkg::MAG_W + qrs_pkg::DEN_W + 3;

  qrs_pkg::q_stat_t           q_stat;
  logic                       push, pop;
  logic [ENTRY_W-1:0]         entry_in, entry_out;
  qrs_pkg::kind_e             kind;
  logic [qrs_pkg::OUT_W-1:0]  first_value, second_value;

  qrs_front #(.FRAC_BITS(FRAC_BITS), .ENTRY_W(ENTRY_W)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .coef_a_i (s_axis_tdata_i[15:0]),
    .coef_b_i (s_axis_tdata_i[31:16]),
    .coef_c_i (s_axis_tdata_i[47:32]),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (entry_in)
  );

  qrs_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry_in),
    .pop_i  (pop),
    .data_o (entry_out),
    .stat_o (q_stat)
  );

  qrs_back #(.FRAC_BITS(FRAC_BITS), .ENTRY_W(ENTRY_W)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (entry_out),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .valid_o        (m_axis_tvalid_o),
    .ready_i        (m_axis_tready_i),
    .root_kind_o    (kind),
    .first_value_o  (first_value),
    .second_value_o (second_value)
  );

  assign m_axis_tdata_o = {second_value, first_value};
  assign m_axis_tuser_o = kind;

  // invalid equations carry zero values
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == qrs_pkg::KIND_INVALID |-> m_axis_tdata_o == '0)
    else $error("invalid kind with nonzero values");

  // a repeated root gives equal values
  a_repeated_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == qrs_pkg::KIND_REPEATED |->
    m_axis_tdata_o[39:0] == m_axis_tdata_o[79:40])
    else $error("repeated root with differing values");

  // a stalled result holds until its transfer
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

endmodule

// ===== test/tb_quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_unit
// Self-checking bench: random and corner-case coefficient sets are streamed in
// with random gaps and output stalls; each transfer out is checked against a
// bit-accurate predictor of the discriminant, fixed-point root and quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// expected root pairs in arrival order, checked against the output stream
class root_scoreboard;
  logic [1:0]  kind_q[$];
  logic [39:0] first_q[$];
  logic [39:0] second_q[$];
  int          errors = 0;

  // floor(sqrt(mag * 4^16)), digit by digit
  function automatic longint unsigned fixed_root(longint unsigned mag);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned pair;
    rem  = 0;
    root = 0;
    for (int i = 0; i < 17 + qrs_pkg::FRAC_BITS; i++) begin
      pair = (i < 17) ? ((mag >> (2 * (16 - i))) & 3) : 0;
      rem  = rem * 4 + pair;
      if (rem >= root * 4 + 1) begin
        rem  = rem - (root * 4 + 1);
        root = root * 2 + 1;
      end else begin
        root = root * 2;
      end
    end
    return root;
  endfunction

  function automatic logic [39:0] clamp40(longint v);
    longint hi;
    hi = (longint'(1) <<< 39) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[39:0];
  endfunction

  // predict the result of one accepted equation
  function void note_equation(logic signed [15:0] ca, logic signed [15:0] cb,
                              logic signed [15:0] cc);
    longint a, b, c, disc, den, base, s, f, g;
    qrs_pkg::kind_e k;
    a = ca;
    b = cb;
    c = cc;
    if (a == 0) begin
      kind_q.push_back(qrs_pkg::KIND_INVALID);
      first_q.push_back('0);
      second_q.push_back('0);
      return;
    end
    disc = b * b - 4 * a * c;
    den  = 2 * a;
    base = -b * (longint'(1) <<< qrs_pkg::FRAC_BITS);
    s    = longint'(fixed_root(disc < 0 ? -disc : disc));
    if (disc > 0) begin
      k = qrs_pkg::KIND_DISTINCT;
      f = (base + s) / den;
      g = (base - s) / den;
    end else if (disc == 0) begin
      k = qrs_pkg::KIND_REPEATED;
      f = base / den;
      g = f;
    end else begin
      k = qrs_pkg::KIND_COMPLEX;
      f = base / den;
      g = s / den;
    end
    kind_q.push_back(k);
    first_q.push_back(clamp40(f));
    second_q.push_back(clamp40(g));
  endfunction

  // compare one output transfer with the oldest prediction
  function void check_roots(logic [1:0] kind, logic [79:0] data);
    logic [1:0]  ek;
    logic [39:0] ef, es;
    if (kind_q.size() == 0) begin
      $display("%0t: unexpected output kind=%0d data=%h", $time, kind, data);
      errors++;
      return;
    end
    ek = kind_q.pop_front();
    ef = first_q.pop_front();
    es = second_q.pop_front();
    if (kind !== ek) begin
      $display("%0t: root_kind expected %0d actual %0d", $time, ek, kind);
      errors++;
    end
    if (data[39:0] !== ef) begin
      $display("%0t: first_value expected %h actual %h", $time, ef, data[39:0]);
      errors++;
    end
    if (data[79:40] !== es) begin
      $display("%0t: second_value expected %h actual %h", $time, es, data[79:40]);
      errors++;
    end
  endfunction

  function int pending();
    return kind_q.size();
  endfunction
endclass

module tb_quadratic_root_solver_unit;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;   // first_value, second_value
  logic [1:0]  m_axis_tuser_o;   // root_kind

  root_scoreboard roots = new();
  int  cycles = 0;
  bit  calm = 1'b0;   // no idling on either side

  quadratic_root_solver_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  always #4 clk_i = ~clk_i;

  // timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sample transfers at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      roots.note_equation(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16],
                          s_axis_tdata_i[47:32]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      roots.check_roots(m_axis_tuser_o, m_axis_tdata_o);
  end

  // output stalls at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 28);
  end

  // send one equation, with an optional gap ahead of it
  task automatic send_equation(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    while (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {c, b, a};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a, b, c, k;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every kind, negative a for the imaginary sign
    send_equation(16'd1, 16'hfffd, 16'd2);      // distinct roots 1 and 2
    send_equation(16'd1, 16'd2, 16'd1);         // repeated root -1
    send_equation(16'd1, 16'd0, 16'd1);         // complex pair
    send_equation(16'hffff, 16'd0, 16'hffff);   // complex, negative a
    send_equation(16'd0, 16'd5, 16'd7);         // invalid
    send_equation(16'd0, 16'h8000, 16'h7fff);   // invalid
    send_equation(16'h8000, 16'h8000, 16'h7fff);
    send_equation(16'h7fff, 16'h8000, 16'h8000);
    send_equation(16'h7fff, 16'h7fff, 16'h7fff);
    send_equation(16'h8000, 16'h8000, 16'h8000);
    send_equation(16'h8000, 16'h7fff, 16'h8000);
    send_equation(16'd1, 16'h8000, 16'h8000);
    send_equation(16'd1, 16'd0, 16'd0);
    send_equation(16'hffff, 16'h7fff, 16'd0);
    send_equation(16'h7fff, 16'd0, 16'h8000);
    send_equation(16'h8000, 16'd0, 16'h7fff);
    send_equation(16'hffff, 16'hffff, 16'hffff);
    send_equation(16'h5555, 16'haaaa, 16'h5555);

    // hold off until the pipeline drains
    s_axis_tvalid_i <= 1'b0;
    while (roots.pending() != 0) @(negedge clk_i);

    // random: mix of repeated-root cases, small and full-range coefficients
    for (int i = 0; i < 2000; i++) begin
      calm = (i >= 800 && i < 1000);
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      if ($urandom_range(7) == 0) begin
        // a*(x-k)^2: b = -2ak, c = ak^2 gives a zero discriminant
        k = 16'(int'($urandom_range(20)) - 10);
        a = 16'(int'($urandom_range(100)) - 50);
        b = 16'(-2 * $signed(a) * $signed(k));
        c = 16'($signed(a) * $signed(k) * $signed(k));
      end
      send_equation(a, b, c);
    end
    s_axis_tvalid_i <= 1'b0;
    calm = 1'b0;

    while (roots.pending() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    if (roots.errors == 0 && roots.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== quadratic_root_solver_unit.f =====
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_queue.sv
hw/rtl/qrs_front.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/qrs_back.sv
hw/rtl/quadratic_root_solver_unit.sv
test/tb_quadratic_root_solver_unit.sv
